[hdl/iwd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwd_pkg
// Instruction identifiers and decode tables for the instruction word decoder.
// ----------------------------------------------------------------------------
package iwd_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned IdW   = 8;

    typedef logic [IdW-1:0] t_id;

    localparam t_id ID_NONE = 8'd0;
    localparam t_id ID_SLL = 8'd44;
    localparam t_id ID_BLTZ = 8'd79;
    localparam t_id ID_MADD = 8'd94;
    localparam t_id ID_EXT = 8'd102;
    localparam t_id ID_INS = 8'd103;
    localparam t_id ID_RDHWR = 8'd104;
    localparam t_id ID_MOVF = 8'd105;
    localparam t_id ID_MOVT = 8'd106;
    localparam t_id ID_SRL = 8'd107;
    localparam t_id ID_ROTR = 8'd108;
    localparam t_id ID_SRLV = 8'd109;
    localparam t_id ID_ROTRV = 8'd110;
    localparam t_id ID_WSBH = 8'd111;
    localparam t_id ID_SEB = 8'd112;
    localparam t_id ID_SEH = 8'd113;
    localparam t_id ID_CVTD = 8'd159;
    localparam t_id ID_CVTS = 8'd179;
    localparam t_id ID_CVTPSPW = 8'd180;
    localparam t_id ID_FMOVF = 8'd190;
    localparam t_id ID_FMOVT = 8'd191;

    localparam logic [5:0] OP_FUNCT    = 6'h00;
    localparam logic [5:0] OP_RTBR     = 6'h01;
    localparam logic [5:0] OP_COP0     = 6'h10;
    localparam logic [5:0] OP_COP1     = 6'h11;
    localparam logic [5:0] OP_COP2     = 6'h12;
    localparam logic [5:0] OP_FPIDX    = 6'h13;
    localparam logic [5:0] OP_FUNCT2   = 6'h1C;
    localparam logic [5:0] OP_FUNCT3   = 6'h1F;

    localparam logic [4:0] FMT_S  = 5'h10;
    localparam logic [4:0] FMT_D  = 5'h11;
    localparam logic [4:0] FMT_W  = 5'h14;
    localparam logic [4:0] FMT_L  = 5'h15;
    localparam logic [4:0] FMT_PS = 5'h16;

    function automatic t_id f_major(input logic [5:0] op);
        case (op)
            6'h02: return 8'd1;   6'h03: return 8'd2;   6'h04: return 8'd3;
            6'h05: return 8'd4;   6'h06: return 8'd5;   6'h07: return 8'd6;
            6'h08: return 8'd7;   6'h09: return 8'd8;   6'h0A: return 8'd9;
            6'h0B: return 8'd10;  6'h0C: return 8'd11;  6'h0D: return 8'd12;
            6'h0E: return 8'd13;  6'h0F: return 8'd14;  6'h14: return 8'd15;
            6'h15: return 8'd16;  6'h16: return 8'd17;  6'h17: return 8'd18;
            6'h1D: return 8'd19;  6'h20: return 8'd20;  6'h21: return 8'd21;
            6'h22: return 8'd22;  6'h23: return 8'd23;  6'h24: return 8'd24;
            6'h25: return 8'd25;  6'h26: return 8'd26;  6'h28: return 8'd27;
            6'h29: return 8'd28;  6'h2A: return 8'd29;  6'h2B: return 8'd30;
            6'h2E: return 8'd31;  6'h2F: return 8'd32;  6'h30: return 8'd33;
            6'h31: return 8'd34;  6'h32: return 8'd35;  6'h33: return 8'd36;
            6'h35: return 8'd37;  6'h36: return 8'd38;  6'h38: return 8'd39;
            6'h39: return 8'd40;  6'h3A: return 8'd41;  6'h3D: return 8'd42;
            6'h3E: return 8'd43;
            default: return ID_NONE;
        endcase
    endfunction

    function automatic t_id f_special(input logic [5:0] fn);
        case (fn)
            6'h00: return 8'd44;  6'h03: return 8'd45;  6'h04: return 8'd46;
            6'h07: return 8'd47;  6'h08: return 8'd48;  6'h09: return 8'd49;
            6'h0A: return 8'd50;  6'h0B: return 8'd51;  6'h0C: return 8'd52;
            6'h0D: return 8'd53;  6'h0F: return 8'd54;  6'h10: return 8'd55;
            6'h11: return 8'd56;  6'h12: return 8'd57;  6'h13: return 8'd58;
            6'h18: return 8'd59;  6'h19: return 8'd60;  6'h1A: return 8'd61;
            6'h1B: return 8'd62;  6'h20: return 8'd63;  6'h21: return 8'd64;
            6'h22: return 8'd65;  6'h23: return 8'd66;  6'h24: return 8'd67;
            6'h25: return 8'd68;  6'h26: return 8'd69;  6'h27: return 8'd70;
            6'h2A: return 8'd71;  6'h2B: return 8'd72;  6'h30: return 8'd73;
            6'h31: return 8'd74;  6'h32: return 8'd75;  6'h33: return 8'd76;
            6'h34: return 8'd77;  6'h36: return 8'd78;
            default: return ID_NONE;
        endcase
    endfunction

    function automatic t_id f_regimm(input logic [4:0] rt);
        case (rt)
            5'h00: return 8'd79;  5'h01: return 8'd80;  5'h02: return 8'd81;
            5'h03: return 8'd82;  5'h08: return 8'd83;  5'h09: return 8'd84;
            5'h0A: return 8'd85;  5'h0B: return 8'd86;  5'h0C: return 8'd87;
            5'h0E: return 8'd88;  5'h10: return 8'd89;  5'h11: return 8'd90;
            5'h12: return 8'd91;  5'h13: return 8'd92;  5'h1F: return 8'd93;
            default: return ID_NONE;
        endcase
    endfunction

    function automatic t_id f_special2(input logic [5:0] fn);
        case (fn)
            6'h00: return 8'd94;  6'h01: return 8'd95;  6'h02: return 8'd96;
            6'h04: return 8'd97;  6'h05: return 8'd98;  6'h20: return 8'd99;
            6'h21: return 8'd100; 6'h3F: return 8'd101;
            default: return ID_NONE;
        endcase
    endfunction

    function automatic t_id f_cop0(input logic [4:0] rs);
        case (rs)
            5'h00: return 8'd114; 5'h04: return 8'd115; 5'h0A: return 8'd116;
            5'h0B: return 8'd117; 5'h0E: return 8'd118;
            default: return ID_NONE;
        endcase
    endfunction

    function automatic t_id f_cop0co(input logic [5:0] fn);
        case (fn)
            6'h01: return 8'd119; 6'h02: return 8'd120; 6'h06: return 8'd121;
            6'h08: return 8'd122; 6'h18: return 8'd123; 6'h1F: return 8'd124;
            6'h20: return 8'd125;
            default: return ID_NONE;
        endcase
    endfunction

    function automatic t_id f_cop1(input logic [4:0] rs);
        case (rs)
            5'h00: return 8'd126; 5'h02: return 8'd127; 5'h03: return 8'd128;
            5'h04: return 8'd129; 5'h06: return 8'd130; 5'h07: return 8'd131;
            5'h08: return 8'd132; 5'h09: return 8'd133; 5'h0A: return 8'd134;
            default: return ID_NONE;
        endcase
    endfunction

    // shared part of the S, D and PS tables
    function automatic t_id f_fp_common(input logic [5:0] fn);
        case (fn)
            6'h00: return 8'd135; 6'h01: return 8'd136; 6'h02: return 8'd137;
            6'h05: return 8'd140; 6'h06: return 8'd141; 6'h07: return 8'd142;
            6'h12: return 8'd151; 6'h13: return 8'd152; 6'h1C: return 8'd155;
            6'h1D: return 8'd156; 6'h1E: return 8'd157; 6'h1F: return 8'd158;
            default: begin
                if (fn[5:4] == 2'b11) return t_id'(8'd163 + {2'b00, fn[3:0]});
                return ID_NONE;
            end
        endcase
    endfunction

    function automatic t_id f_fp_sd(input logic [5:0] fn, input logic is_d);
        case (fn)
            6'h03: return 8'd138; 6'h04: return 8'd139;
            6'h08: return 8'd143; 6'h09: return 8'd144; 6'h0A: return 8'd145;
            6'h0B: return 8'd146; 6'h0C: return 8'd147; 6'h0D: return 8'd148;
            6'h0E: return 8'd149; 6'h0F: return 8'd150;
            6'h15: return 8'd153; 6'h16: return 8'd154;
            6'h1F: return 8'd158;
            6'h20: return is_d ? ID_CVTS : ID_NONE;
            6'h21: return is_d ? ID_NONE : ID_CVTD;
            6'h24: return 8'd160; 6'h25: return 8'd161;
            6'h26: return is_d ? ID_NONE : 8'd162;
            default: return f_fp_common(fn);
        endcase
    endfunction

    function automatic t_id f_fp_ps(input logic [5:0] fn);
        case (fn)
            6'h18: return 8'd181; 6'h1A: return 8'd182; 6'h20: return 8'd183;
            6'h24: return 8'd184; 6'h28: return 8'd185; 6'h2C: return 8'd186;
            6'h2D: return 8'd187; 6'h2E: return 8'd188; 6'h2F: return 8'd189;
            default: return f_fp_common(fn);
        endcase
    endfunction

    function automatic t_id f_cop2(input logic [4:0] rs);
        case (rs)
            5'h00: return 8'd192; 5'h02: return 8'd193; 5'h03: return 8'd194;
            5'h04: return 8'd195; 5'h06: return 8'd196; 5'h07: return 8'd197;
            5'h08: return 8'd198;
            default: return ID_NONE;
        endcase
    endfunction

    function automatic t_id f_cop1x(input logic [5:0] fn);
        case (fn)
            6'h00: return 8'd199; 6'h01: return 8'd200; 6'h05: return 8'd201;
            6'h08: return 8'd202; 6'h09: return 8'd203; 6'h0D: return 8'd204;
            6'h0F: return 8'd205; 6'h1E: return 8'd206; 6'h20: return 8'd207;
            6'h21: return 8'd208; 6'h26: return 8'd209; 6'h28: return 8'd210;
            6'h29: return 8'd211; 6'h2E: return 8'd212; 6'h30: return 8'd213;
            6'h31: return 8'd214; 6'h36: return 8'd215; 6'h38: return 8'd216;
            6'h39: return 8'd217; 6'h3E: return 8'd218;
            default: return ID_NONE;
        endcase
    endfunction

endpackage

[hdl/instruction_word_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// instruction_word_decoder
// Maps a 32-bit instruction word to a dense 8-bit identifier.
// ----------------------------------------------------------------------------
//  port            dir  width  role
//  i_start         in   1      word offered, taken when o_busy is low
//  i_instr_word    in   32     instruction word
//  o_valid         out  1      result strobe, one cycle
//  o_instr_id      out  8      identifier, 0 for reserved
//
//  One word per cycle; its identifier appears on the next cycle.
//  The table lookup and one result register set that latency.
//  o_busy is low at all times; the receiver cannot stall.
//  Reset clears the strobe only.
// ----------------------------------------------------------------------------
module instruction_word_decoder import iwd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WordW-1:0] i_instr_word,
    output logic             o_busy,
    output logic             o_valid,
    output logic [IdW-1:0]   o_instr_id
);

    logic       r_valid;
    t_id        r_id;
    t_id        n_id;
    logic [5:0] op;
    logic [4:0] rs;
    logic [4:0] rt;
    logic [4:0] sa;
    logic [5:0] fn;

    assign op = i_instr_word[31:26];
    assign rs = i_instr_word[25:21];
    assign rt = i_instr_word[20:16];
    assign sa = i_instr_word[10:6];
    assign fn = i_instr_word[5:0];

    always_comb begin
        n_id = ID_NONE;
        case (op)
            OP_FUNCT: begin
                if (fn == 6'h01)      n_id = i_instr_word[16] ? ID_MOVT : ID_MOVF;
                else if (fn == 6'h02) n_id = i_instr_word[21] ? ID_ROTR : ID_SRL;
                else if (fn == 6'h06) n_id = i_instr_word[6] ? ID_ROTRV : ID_SRLV;
                else                  n_id = f_special(fn);
            end
            OP_RTBR:   n_id = f_regimm(rt);
            OP_COP0:   n_id = rs[4] ? f_cop0co(fn) : f_cop0(rs);
            OP_COP1: begin
                if ((rs == FMT_S || rs == FMT_D || rs == FMT_PS) && fn == 6'h11)
                    n_id = i_instr_word[16] ? ID_FMOVT : ID_FMOVF;
                else if (rs == FMT_S)  n_id = f_fp_sd(fn, 1'b0);
                else if (rs == FMT_D)  n_id = f_fp_sd(fn, 1'b1);
                else if (rs == FMT_PS) n_id = f_fp_ps(fn);
                else if (rs == FMT_W || rs == FMT_L) begin
                    if (fn == 6'h20)      n_id = ID_CVTS;
                    else if (fn == 6'h21) n_id = ID_CVTD;
                    else if (fn == 6'h26) n_id = ID_CVTPSPW;
                    else                  n_id = ID_NONE;
                end else begin
                    n_id = f_cop1(rs);
                end
            end
            OP_COP2:   n_id = rs[4] ? ID_NONE : f_cop2(rs);
            OP_FPIDX:  n_id = f_cop1x(fn);
            OP_FUNCT2: n_id = f_special2(fn);
            OP_FUNCT3: begin
                if (fn == 6'h00)      n_id = ID_EXT;
                else if (fn == 6'h04) n_id = ID_INS;
                else if (fn == 6'h3B) n_id = ID_RDHWR;
                else if (fn == 6'h20 && sa == 5'h02) n_id = ID_WSBH;
                else if (fn == 6'h20 && sa == 5'h10) n_id = ID_SEB;
                else if (fn == 6'h20 && sa == 5'h18) n_id = ID_SEH;
                else n_id = ID_NONE;
            end
            default: n_id = f_major(op);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_start;
        end
        r_id <= n_id;
    end

    assign o_busy     = 1'b0;
    assign o_valid    = r_valid;
    assign o_instr_id = r_id;

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> o_valid) else $error("strobe lost");
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_start |=> !o_valid) else $error("spurious strobe");
    a_cop2_co: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && op == OP_COP2 && rs[4]) |=> (o_instr_id == ID_NONE))
        else $error("cop2 co not reserved");

endmodule
